@@ design/cgsm_pkg.sv @@
// ---------------------------------------------------------------------------
// cgsm_pkg - shared types and constants of the glyph segment map
// Word layouts, operation and status codes, memory geometry.
// ---------------------------------------------------------------------------
package cgsm_pkg;

    localparam int SEGMENTS     = 256;
    localparam int STREAM_BYTES = 8192;
    localparam int SEG_AW       = $clog2(SEGMENTS);
    localparam int STREAM_AW    = $clog2(STREAM_BYTES);
    localparam int ROW_AW       = STREAM_AW - 1;
    localparam int ROWS         = STREAM_BYTES / 2;

    localparam logic [1:0] OP_LOAD_SEG  = 2'd0;
    localparam logic [1:0] OP_LOAD_BYTE = 2'd1;
    localparam logic [1:0] OP_LOOKUP    = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_GLYPH_RANGE = 2'd1;
    localparam logic [1:0] ST_STREAM_OOB  = 2'd2;

    localparam logic [1:0] CFG_SEG_COUNT    = 2'd0;
    localparam logic [1:0] CFG_NUM_GLYPHS   = 2'd1;
    localparam logic [1:0] CFG_STREAM_BYTES = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         seg_index;
        logic [15:0]        start_code;
        logic [15:0]        end_code;
        logic signed [15:0] id_delta;
        logic [15:0]        range_offset;
        logic [12:0]        byte_address;
        logic [7:0]         byte_value;
        logic [15:0]        char_code;
    } t_in;

    typedef struct packed {
        logic [15:0] glyph_id;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic [15:0] seg_start;
        logic [15:0] seg_end;
        logic [15:0] seg_delta;
        logic [15:0] seg_offset;
    } t_seg;

    typedef struct packed {
        logic                 en;
        logic [STREAM_AW-1:0] addr;
        logic [7:0]           data;
    } t_strm_wr;

    typedef struct packed {
        logic                 en;
        logic [STREAM_AW-1:0] pos;
    } t_strm_rd;

endpackage

@@ design/cgsm_stream_store.sv @@
// ---------------------------------------------------------------------------
// cgsm_stream_store - big-endian word stream store
// Byte writes; reads a 16-bit word at any byte position from two banks.
// ---------------------------------------------------------------------------
module cgsm_stream_store
    import cgsm_pkg::*;
(
    input  logic        i_clk,
    input  t_strm_wr    i_wr,
    input  t_strm_rd    i_rd,
    output logic [15:0] o_word
);

    logic [7:0] mem_even [ROWS];
    logic [7:0] mem_odd  [ROWS];
    logic [7:0] r_q_even;
    logic [7:0] r_q_odd;
    logic       r_lsb;

    logic [ROW_AW-1:0] w_row_odd;
    logic [ROW_AW-1:0] w_row_even;

    // odd position: high byte from odd bank, low byte from the next even row
    assign w_row_odd  = i_rd.pos[STREAM_AW-1:1];
    assign w_row_even = i_rd.pos[STREAM_AW-1:1] + ROW_AW'(i_rd.pos[0]);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (i_wr.addr[0]) begin
                mem_odd[i_wr.addr[STREAM_AW-1:1]] <= i_wr.data;
            end else begin
                mem_even[i_wr.addr[STREAM_AW-1:1]] <= i_wr.data;
            end
        end
        if (i_rd.en) begin
            r_q_even <= mem_even[w_row_even];
            r_q_odd  <= mem_odd[w_row_odd];
            r_lsb    <= i_rd.pos[0];
        end
    end

    assign o_word = r_lsb ? {r_q_odd, r_q_even} : {r_q_even, r_q_odd};

endmodule

@@ design/char_to_glyph_segment_map.sv @@
// ---------------------------------------------------------------------------
// char_to_glyph_segment_map - segment table character to glyph lookup
// Segment memory scan with stream word fetch and registered result.
// ---------------------------------------------------------------------------
// Usage:
//   Input words carry an opcode: load segment, load stream byte or lookup.
//   Loads are taken in the idle state and give no result. A lookup gives one output word
//   (glyph_id, status) on the valid/ready output channel.
//   A lookup scans the segment memory one entry per cycle. Its steps are the
//   accept, the scan up to the hit or stop segment, a bounds check when the
//   hit segment has a range offset, a stream store fetch when that check
//   passes, and the load into the output register; with seg_count 0 the
//   scan is skipped.
//   The single-port segment memory read per cycle sets the scan rate.
//   One item is worked on at a time; the input is ready again once the
//   result sits in the output register, so the next word is taken while a
//   result waits for the receiver. A stalled receiver holds the result and
//   a following lookup waits at its end until the output register frees.
//   Reset (synchronous, active low) sets seg_count 1, num_glyphs 65535,
//   stream_bytes 0 and empties the output. Memory contents are kept and
//   must be loaded before they are read.
//   Configuration writes go in through i_cfg_we / i_cfg_idx / i_cfg_data.
// ---------------------------------------------------------------------------
module char_to_glyph_segment_map
    import cgsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_BND  = 3'd2;
    localparam logic [2:0] S_STRM = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  r_state;
    logic [8:0]  r_seg_count;
    logic [15:0] r_num_glyphs;
    logic [13:0] r_stream_bytes;

    logic [SEG_AW-1:0] r_idx;
    logic [15:0]       r_code;
    logic [15:0]       r_pos;
    logic [15:0]       r_delta;
    logic [15:0]       r_glyph;
    logic              r_mapped;
    logic              r_oob;
    logic              r_out_valid;
    t_out              r_out;

    t_seg seg_mem [SEGMENTS];
    t_seg r_seg_q;

    logic              w_accept;
    logic [SEG_AW-1:0] w_rd_addr;
    logic [8:0]        w_count;
    logic              w_last;
    logic [15:0]       w_rel;
    logic [15:0]       w_pos;
    logic [15:0]       w_delta_glyph;
    logic [13:0]       w_limit;
    logic              w_out_free;
    logic [15:0]       w_word;
    t_strm_wr          w_wr;
    t_strm_rd          w_rd;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_count = (r_seg_count > 9'(SEGMENTS)) ? 9'(SEGMENTS) : r_seg_count;
    assign w_last  = ({1'b0, r_idx} == (w_count - 9'd1));
    assign w_limit = (r_stream_bytes > 14'(STREAM_BYTES)) ? 14'(STREAM_BYTES)
                                                          : r_stream_bytes;

    assign w_rel         = r_code - r_seg_q.seg_start + 16'(r_idx);
    assign w_pos         = r_seg_q.seg_offset + {w_rel[14:0], 1'b0};
    assign w_delta_glyph = r_code + r_seg_q.seg_delta;

    // entry 0 is read while idle so a new lookup has its first segment at once
    assign w_rd_addr = (r_state == S_SCAN) ? r_idx + SEG_AW'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.opcode == OP_LOAD_SEG) begin
            seg_mem[i_in_data.seg_index[SEG_AW-1:0]] <= '{
                seg_start:  i_in_data.start_code,
                seg_end:    i_in_data.end_code,
                seg_delta:  $unsigned(i_in_data.id_delta),
                seg_offset: i_in_data.range_offset
            };
        end
        r_seg_q <= seg_mem[w_rd_addr];
    end

    always_comb begin
        w_wr.en   = w_accept && (i_in_data.opcode == OP_LOAD_BYTE);
        w_wr.addr = i_in_data.byte_address[STREAM_AW-1:0];
        w_wr.data = i_in_data.byte_value;
        w_rd.en   = (r_state == S_BND);
        w_rd.pos  = r_pos[STREAM_AW-1:0];
    end

    cgsm_stream_store u_stream (
        .i_clk  (i_clk),
        .i_wr   (w_wr),
        .i_rd   (w_rd),
        .o_word (w_word)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count    <= 9'd1;
            r_num_glyphs   <= 16'hFFFF;
            r_stream_bytes <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEG_COUNT:    r_seg_count    <= i_cfg_data[8:0];
                CFG_NUM_GLYPHS:   r_num_glyphs   <= i_cfg_data;
                CFG_STREAM_BYTES: r_stream_bytes <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // lookup sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_in_data.opcode == OP_LOOKUP) begin
                        r_code   <= i_in_data.char_code;
                        r_idx    <= '0;
                        r_glyph  <= '0;
                        r_mapped <= 1'b0;
                        r_oob    <= 1'b0;
                        r_state  <= (w_count == 9'd0) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_code > r_seg_q.seg_end) begin
                        if (w_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx + SEG_AW'(1);
                        end
                    end else if (r_code < r_seg_q.seg_start) begin
                        r_state <= S_DONE;
                    end else if (r_seg_q.seg_offset == 16'd0) begin
                        r_glyph  <= w_delta_glyph;
                        r_mapped <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_pos   <= w_pos;
                        r_delta <= r_seg_q.seg_delta;
                        r_state <= S_BND;
                    end
                end
                S_BND: begin
                    // both bytes must lie inside the loaded stream
                    if (({1'b0, r_pos} + 17'd2) > {3'b000, w_limit}) begin
                        r_oob   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_STRM;
                    end
                end
                S_STRM: begin
                    r_glyph  <= (w_word != 16'd0) ? w_word + r_delta : 16'd0;
                    r_mapped <= 1'b1;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out.glyph_id <= r_glyph;
            if (r_oob) begin
                r_out.status <= ST_STREAM_OOB;
            end else if (r_mapped && r_glyph >= r_num_glyphs) begin
                r_out.status <= ST_GLYPH_RANGE;
            end else begin
                r_out.status <= ST_OK;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // new result only comes from the finishing state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word appeared without a finished lookup");

    // scan never runs past the consulted segment count
    a_scan_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_idx} < w_count))
        else $error("segment scan beyond segment count");

    // out-of-bounds stream read reports glyph zero
    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_STREAM_OOB) |->
            (o_out_data.glyph_id == 16'd0))
        else $error("stream read error with nonzero glyph");

    // a pending result word is held unchanged while the receiver stalls
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_out_data)))
        else $error("pending result word overwritten");

endmodule

@@ bench/char_to_glyph_segment_map_tb.sv @@
// ---------------------------------------------------------------------------
// char_to_glyph_segment_map_tb - self-checking bench of the glyph segment map
// Loads segment tables and stream bytes, looks up character codes under
// several register settings and compares each result word against a local
// scan of the same tables. Random idling on both channels, a long output
// hold and a fully loaded 256-segment table are part of the run.
// ---------------------------------------------------------------------------
module char_to_glyph_segment_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cgsm_pkg::*;

    localparam int          RESET_CYCLES  = 7;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 1500;
    localparam int          TABLE_ROUNDS  = 12;
    localparam int          NOISE_WORDS   = 330;
    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam logic [1:0]  OP_RESERVED   = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;

    // local copy of the tables and registers
    logic [15:0] seg_first  [SEGMENTS];
    logic [15:0] seg_last   [SEGMENTS];
    logic [15:0] seg_shift  [SEGMENTS];
    logic [15:0] seg_offset [SEGMENTS];
    bit          seg_known  [SEGMENTS];
    logic [7:0]  byte_mem   [STREAM_BYTES];
    bit          byte_known [STREAM_BYTES];
    int unsigned cfg_seg_count  = 1;
    int unsigned cfg_num_glyphs = 65535;
    int unsigned cfg_stream_len = 0;

    t_out        pending_glyphs[$];
    int unsigned fail_count   = 0;
    int unsigned lookups_sent = 0;
    int unsigned results_seen = 0;
    int unsigned seg_loads    = 0;
    int unsigned byte_loads   = 0;
    int unsigned reg_writes   = 0;
    int unsigned cycle_count  = 0;
    bit          idle_en      = 1'b1;
    bit          hold_req     = 1'b0;

    char_to_glyph_segment_map u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_glyphs.size());
            $display("char_to_glyph_segment_map_tb failed");
            $finish;
        end
    end

    // Mapping of one code under the current tables. Returns 0 when the scan
    // would touch a segment or stream byte that was never loaded.
    function automatic bit glyph_for_code(input logic [15:0] code, output t_out res);
        int unsigned n, lim, pos, g, c;
        res = '0;
        c   = 32'(code);
        n   = (cfg_seg_count > SEGMENTS) ? SEGMENTS : cfg_seg_count;
        lim = (cfg_stream_len > STREAM_BYTES) ? STREAM_BYTES : cfg_stream_len;
        for (int unsigned i = 0; i < n; i++) begin
            if (!seg_known[i]) return 1'b0;
            if (c > 32'(seg_last[i])) continue;
            if (c < 32'(seg_first[i])) return 1'b1;
            if (seg_offset[i] == 16'd0) begin
                g = (c + 32'(seg_shift[i])) & 32'hFFFF;
            end else begin
                pos = (32'(seg_offset[i]) + 2 * (c - 32'(seg_first[i]) + i)) & 32'hFFFF;
                if (pos + 2 > lim) begin
                    res.status = ST_STREAM_OOB;
                    return 1'b1;
                end
                if (!byte_known[pos] || !byte_known[pos + 1]) return 1'b0;
                g = 32'({byte_mem[pos], byte_mem[pos + 1]});
                // a zero word stays unmapped, no delta
                if (g != 0) g = (g + 32'(seg_shift[i])) & 32'hFFFF;
            end
            res.glyph_id = g[15:0];
            res.status   = (g >= cfg_num_glyphs) ? ST_GLYPH_RANGE : ST_OK;
            return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void apply_word(input t_in w);
        t_out res;
        case (w.opcode)
            OP_LOAD_SEG: begin
                seg_first[w.seg_index]  = w.start_code;
                seg_last[w.seg_index]   = w.end_code;
                seg_shift[w.seg_index]  = w.id_delta;
                seg_offset[w.seg_index] = w.range_offset;
                seg_known[w.seg_index]  = 1'b1;
                seg_loads++;
            end
            OP_LOAD_BYTE: begin
                byte_mem[w.byte_address]   = w.byte_value;
                byte_known[w.byte_address] = 1'b1;
                byte_loads++;
            end
            OP_LOOKUP: begin
                void'(glyph_for_code(w.char_code, res));
                pending_glyphs.push_back(res);
                lookups_sent++;
            end
            default: ;
        endcase
    endfunction

    function automatic t_in scramble_word();
        t_in w;
        w.opcode       = 2'($urandom());
        w.seg_index    = 8'($urandom());
        w.start_code   = 16'($urandom());
        w.end_code     = 16'($urandom());
        w.id_delta     = 16'($urandom());
        w.range_offset = 16'($urandom());
        w.byte_address = 13'($urandom());
        w.byte_value   = 8'($urandom());
        w.char_code    = 16'($urandom());
        return w;
    endfunction

    function automatic t_in seg_word(input int unsigned idx, input logic [15:0] lo,
                                     input logic [15:0] hi, input logic [15:0] dl,
                                     input logic [15:0] ro);
        t_in w;
        w              = scramble_word();
        w.opcode       = OP_LOAD_SEG;
        w.seg_index    = 8'(idx);
        w.start_code   = lo;
        w.end_code     = hi;
        w.id_delta     = dl;
        w.range_offset = ro;
        return w;
    endfunction

    function automatic t_in byte_word(input int unsigned addr, input logic [7:0] val);
        t_in w;
        w              = scramble_word();
        w.opcode       = OP_LOAD_BYTE;
        w.byte_address = 13'(addr);
        w.byte_value   = val;
        return w;
    endfunction

    function automatic t_in lookup_word(input logic [15:0] code);
        t_in w;
        w           = scramble_word();
        w.opcode    = OP_LOOKUP;
        w.char_code = code;
        return w;
    endfunction

    // Offer one word and hold it until taken. Valid stays high afterwards.
    task automatic send_word(input t_in w);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        apply_word(w);
    endtask

    task automatic lookup_code(input logic [15:0] code);
        t_out res;
        if (glyph_for_code(code, res)) send_word(lookup_word(code));
    endtask

    // Drop valid, drain all results, let a trailing load finish.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_glyphs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        logic [15:0] data;
        data = 16'($urandom());
        case (idx)
            CFG_SEG_COUNT:    data[8:0]  = 9'(val);
            CFG_NUM_GLYPHS:   data       = 16'(val);
            CFG_STREAM_BYTES: data[13:0] = 14'(val);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SEG_COUNT:    cfg_seg_count  = 32'(data[8:0]);
            CFG_NUM_GLYPHS:   cfg_num_glyphs = 32'(data);
            CFG_STREAM_BYTES: cfg_stream_len = 32'(data[13:0]);
            default: ;
        endcase
        reg_writes++;
    endtask

    function automatic logic [15:0] near_code(input int unsigned n);
        int unsigned i;
        i = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0:       return 16'($urandom());
            1:       return 16'(seg_first[i] - 16'd1);
            2:       return 16'(seg_last[i] + 16'd1);
            default: return 16'(seg_first[i] + $urandom_range(0, 16'(seg_last[i] - seg_first[i])));
        endcase
    endfunction

    // Ascending segments in slots 0..n-1 closed by the usual 0xFFFF segment;
    // some segments point at a glyph array written behind stream_end.
    task automatic build_table(input int unsigned n, output int unsigned stream_end);
        int unsigned lo, hi, cur, kind;
        logic [15:0] ro;
        bit          zero;
        stream_end = $urandom_range(0, STREAM_BYTES - 160);
        cur        = $urandom_range(0, 50000);
        for (int unsigned i = 0; i < n; i++) begin
            kind = $urandom_range(0, 3);
            lo   = cur + $urandom_range(0, 300);
            hi   = lo + ((kind == 2) ? $urandom_range(0, 5) : $urandom_range(0, 40));
            if (i == n - 1 || hi > 32'hFFFE) begin
                lo   = 32'hFFFF;
                hi   = 32'hFFFF;
                kind = 0;
            end
            cur = hi + 1;
            case (kind)
                2:       ro = 16'(stream_end - 2 * i);
                3:       ro = 16'($urandom_range(STREAM_BYTES, 32'hF000));
                default: ro = 16'd0;
            endcase
            send_word(seg_word(i, 16'(lo), 16'(hi), 16'($urandom()), ro));
            if (kind == 2) begin
                for (int unsigned k = 0; k < 2 * (hi - lo + 1); k += 2) begin
                    zero = ($urandom_range(0, 4) == 0);
                    send_word(byte_word(stream_end + k, zero ? 8'd0 : 8'($urandom())));
                    send_word(byte_word(stream_end + k + 1, zero ? 8'd0 : 8'($urandom())));
                end
                stream_end += 2 * (hi - lo + 1);
            end
        end
    endtask

    task automatic test_directed_cases();
        t_in w;
        // reset settings: one segment, 65535 glyphs, empty stream
        send_word(seg_word(0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd0));
        lookup_code(16'h0000);
        lookup_code(16'hFFFF);
        w        = scramble_word();
        w.opcode = OP_RESERVED;
        send_word(w);
        send_word(seg_word(0, 16'h1000, 16'h1FFF, 16'h7FFF, 16'd0));
        lookup_code(16'h0FFF);
        lookup_code(16'h2000);
        lookup_code(16'h1000);
        wait_idle();
        write_reg(CFG_STREAM_BYTES, 16383);
        write_reg(CFG_NUM_GLYPHS, 0);
        write_reg(CFG_SEG_COUNT, 2);
        send_word(seg_word(0, 16'h0000, 16'h0FFF, 16'h0000, 16'd0));
        send_word(seg_word(1, 16'h2000, 16'h2000, 16'h8000, 16'd8188));
        send_word(byte_word(STREAM_BYTES - 2, 8'h00));
        send_word(byte_word(STREAM_BYTES - 1, 8'h01));
        lookup_code(16'h2000);
        lookup_code(16'h0000);
        lookup_code(16'h1800);
        // odd offset placing the word wholly past the end of the store
        send_word(seg_word(1, 16'h2000, 16'h2001, 16'h1234, 16'd8189));
        lookup_code(16'h2001);
        // position wraps to zero; a zero word gets no delta
        send_word(seg_word(1, 16'h2000, 16'h2000, 16'h1234, 16'hFFFE));
        send_word(byte_word(0, 8'h00));
        send_word(byte_word(1, 8'h00));
        lookup_code(16'h2000);
        wait_idle();
        write_reg(CFG_SEG_COUNT, 0);
        write_reg(CFG_STREAM_BYTES, 0);
        lookup_code(16'h0000);
        wait_idle();
        write_reg(CFG_SEG_COUNT, 2);
        write_reg(CFG_NUM_GLYPHS, 65535);
        lookup_code(16'h2000);
        wait_idle();
    endtask

    task automatic test_segment_tables();
        int unsigned n, stream_end;
        repeat (TABLE_ROUNDS) begin
            idle_en = ($urandom_range(0, 3) != 0);
            n       = $urandom_range(2, 12);
            build_table(n, stream_end);
            wait_idle();
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_STREAM_BYTES, STREAM_BYTES);
                1:       write_reg(CFG_STREAM_BYTES, 16383);
                2:       write_reg(CFG_STREAM_BYTES, stream_end - $urandom_range(1, 4));
                default: write_reg(CFG_STREAM_BYTES, stream_end);
            endcase
            write_reg(CFG_SEG_COUNT, ($urandom_range(0, 3) == 0) ? n - 1 : n);
            write_reg(CFG_NUM_GLYPHS, 65535);
            repeat (15) lookup_code(near_code(n));
            wait_idle();
            write_reg(CFG_NUM_GLYPHS, ($urandom_range(0, 1) == 0) ?
                      $urandom_range(1, 300) : $urandom_range(0, 65535));
            write_reg(CFG_SEG_COUNT, $urandom_range(1, n));
            repeat (15) lookup_code(near_code(n));
            wait_idle();
        end
    endtask

    task automatic test_full_table();
        int unsigned region, lo, hi;
        logic [15:0] ro;
        idle_en = 1'b1;
        region  = $urandom_range(0, STREAM_BYTES - 8);
        for (int unsigned i = 0; i < SEGMENTS; i++) begin
            lo = i * 256;
            // every 32nd segment reads four words from one shared region;
            // the last one leaves the top codes uncovered
            if (i % 32 == 31) begin
                hi = lo + 3;
                ro = 16'(region - 2 * i);
            end else begin
                hi = lo + $urandom_range(0, 200);
                ro = 16'd0;
            end
            send_word(seg_word(i, 16'(lo), 16'(hi), 16'($urandom()), ro));
        end
        for (int unsigned k = 0; k < 8; k++) send_word(byte_word(region + k, 8'($urandom())));
        wait_idle();
        write_reg(CFG_STREAM_BYTES, STREAM_BYTES);
        write_reg(CFG_NUM_GLYPHS, $urandom_range(0, 65535));
        write_reg(CFG_SEG_COUNT, SEGMENTS);
        repeat (20) lookup_code(16'($urandom()));
        repeat (10) lookup_code(16'($urandom_range(16'hFF04, 16'hFFFF)));
        wait_idle();
        write_reg(CFG_SEG_COUNT, 511);
        repeat (10) lookup_code(16'($urandom()));
        repeat (5) lookup_code(16'($urandom_range(16'hFF04, 16'hFFFF)));
        wait_idle();
        write_reg(CFG_SEG_COUNT, 0);
        repeat (3) lookup_code(16'($urandom()));
        wait_idle();
        write_reg(CFG_SEG_COUNT, $urandom_range(2, SEGMENTS - 1));
        repeat (10) lookup_code(16'($urandom()));
        wait_idle();
    endtask

    task automatic test_output_hold();
        // stall the receiver while lookups keep coming, then drain fully
        hold_req = 1'b1;
        repeat (12) lookup_code(16'($urandom()));
        wait_idle();
    endtask

    task automatic test_random_noise();
        t_in w;
        idle_en = 1'b1;
        repeat (NOISE_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: lookup_code(16'($urandom()));
                3, 4: begin
                    w        = scramble_word();
                    w.opcode = OP_LOAD_SEG;
                    send_word(w);
                end
                5, 6: begin
                    w        = scramble_word();
                    w.opcode = OP_LOAD_BYTE;
                    send_word(w);
                end
                default: begin
                    w        = scramble_word();
                    w.opcode = OP_RESERVED;
                    send_word(w);
                end
            endcase
        end
        wait_idle();
    endtask

    task automatic test_steady_stream();
        int unsigned n, stream_end;
        idle_en = 1'b0;
        n       = $urandom_range(8, 12);
        build_table(n, stream_end);
        wait_idle();
        write_reg(CFG_STREAM_BYTES, stream_end);
        write_reg(CFG_SEG_COUNT, n);
        write_reg(CFG_NUM_GLYPHS, $urandom_range(0, 65535));
        repeat (60) lookup_code(near_code(n));
        wait_idle();
    endtask

    // receiver: random stall bursts, or one long hold on request
    initial begin : out_side
        int unsigned stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0) begin
                if (hold_req) begin
                    stall_left = HOLD_CYCLES;
                    hold_req   = 1'b0;
                end else if (idle_en && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 14);
                end
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_glyphs.size() == 0) begin
                $error("result word with none expected: glyph_id %h status %0d",
                       o_out_data.glyph_id, o_out_data.status);
                fail_count++;
            end else begin
                want = pending_glyphs.pop_front();
                results_seen++;
                if (o_out_data.glyph_id !== want.glyph_id) begin
                    $error("glyph_id: expected %h, actual %h",
                           want.glyph_id, o_out_data.glyph_id);
                    fail_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_out_data.status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_segment_tables();
        test_full_table();
        test_output_hold();
        test_random_noise();
        test_steady_stream();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (pending_glyphs.size() != 0) begin
            $error("%0d expected results never arrived", pending_glyphs.size());
            fail_count++;
        end
        $display("covered %0d lookups (%0d results), %0d segment and %0d stream byte loads",
                 lookups_sent, results_seen, seg_loads, byte_loads);
        $display("%0d register writes, %0d mismatches, %0d cycles",
                 reg_writes, fail_count, cycle_count);
        if (fail_count == 0) begin
            $display("char_to_glyph_segment_map_tb passed");
        end else begin
            $display("char_to_glyph_segment_map_tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/cgsm_pkg.sv
design/cgsm_stream_store.sv
design/char_to_glyph_segment_map.sv
bench/char_to_glyph_segment_map_tb.sv
